// File: design/elliptic_envelope_dilation_defines.svh
// Assertion macros shared by the envelope dilation design.
// Depends on nothing; files that check take it by include.
`ifndef ELLIPTIC_ENVELOPE_DILATION_DEFINES_SVH
`define ELLIPTIC_ENVELOPE_DILATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define EED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define EED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/eed_pkg.sv
// Shared types and constants of the elliptic envelope dilation block.
// No dependencies; used by eed_root, eed_cell and the top level.
package eed_pkg;

  typedef enum logic [2:0] {
    R_IDLE,
    R_MUL,
    R_PREP,
    R_ROOT,
    R_SCALE,
    R_DONE
  } root_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUILD,
    T_WAIT,
    T_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctrl_t;

  localparam logic [1:0] CFG_HALF_WINDOW = 2'd0;
  localparam logic [1:0] CFG_MARGIN      = 2'd1;
  localparam logic [1:0] CFG_RATIO_SQ    = 2'd2;

  localparam logic [6:0]  HALF_WINDOW_RST = 7'd8;
  localparam logic [30:0] MARGIN_RST      = 31'd65536;
  localparam logic [31:0] RATIO_SQ_RST    = 32'd33554432;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

endpackage

// File: design/eed_root.sv
// Radius generator: r(j) = margin * sqrt(1 - j*j*ratio_sq), one bit of root per cycle.
// Depends on eed_pkg.
module eed_root #(
  parameter int MAX_HALF_WINDOW = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0] j,
  input  logic [31:0]                          ratio,
  input  logic [30:0]                          margin,
  output logic                                 done,
  output logic [31:0]                          radius
);
  localparam int DW = $clog2(MAX_HALF_WINDOW + 1);

  eed_pkg::root_state_t state, state_next;

  logic [2*DW-1:0]  jsq;
  logic [2*DW+31:0] prod;
  logic [63:0]      radicand;
  logic [35:0]      rem;
  logic [31:0]      root;
  logic [4:0]       step;
  logic [62:0]      scaled;

  logic        prod_big;
  logic [31:0] a;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign prod_big = |prod[2*DW+31:31];
  assign a        = prod_big ? 32'd0 : (eed_pkg::ONE_Q31 - prod[31:0]);
  assign rem_sh   = {rem[33:0], radicand[63:62]};
  assign trial    = {2'b00, root, 2'b01};

  always_comb begin
    state_next = state;
    case (state)
      eed_pkg::R_IDLE:  if (start) state_next = eed_pkg::R_MUL;
      eed_pkg::R_MUL:   state_next = eed_pkg::R_PREP;
      eed_pkg::R_PREP:  state_next = eed_pkg::R_ROOT;
      eed_pkg::R_ROOT:  if (step == 5'd0) state_next = eed_pkg::R_SCALE;
      eed_pkg::R_SCALE: state_next = eed_pkg::R_DONE;
      eed_pkg::R_DONE:  state_next = eed_pkg::R_IDLE;
      default:          state_next = eed_pkg::R_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    case (state)
      eed_pkg::R_DONE: done = 1'b1;
      default:         done = 1'b0;
    endcase
  end

  assign radius = scaled[62:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eed_pkg::R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      eed_pkg::R_IDLE: begin
        jsq <= j * j;
      end
      eed_pkg::R_MUL: begin
        prod <= jsq * ratio;
      end
      eed_pkg::R_PREP: begin
        radicand <= {1'b0, a, 31'd0};
        rem      <= '0;
        root     <= '0;
        step     <= 5'd31;
      end
      eed_pkg::R_ROOT: begin
        // one restoring step per cycle
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        radicand <= {radicand[61:0], 2'b00};
        step     <= step - 5'd1;
      end
      eed_pkg::R_SCALE: begin
        scaled <= margin * root;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/eed_cell.sv
// One window cell: a stationary radius and a travelling max/min slot.
// Depends on eed_pkg.
module eed_cell #(
  parameter int SAMPLE_BITS     = 32,
  parameter int MAX_HALF_WINDOW = 64,
  parameter int POS             = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  eed_pkg::cell_ctrl_t                  ctrl,
  input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0] half,
  input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0] load_j,
  input  logic [31:0]                          load_radius,
  input  logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] x,
  input  logic                                 nb_valid,
  input  logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] nb_up,
  input  logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] nb_lo,
  input  logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] nb_center,
  output logic                                 out_valid,
  output logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] out_up,
  output logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] out_lo,
  output logic signed [((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32)+1:0] out_center
);
  localparam int DW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int PW = DW + 1;
  localparam int AW = ((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32) + 2;
  localparam logic [PW-1:0] POS_V = PW'(POS);

  logic                 valid;
  logic signed [AW-1:0] up;
  logic signed [AW-1:0] lo;
  logic signed [AW-1:0] center;
  logic [31:0]          radius;

  logic [PW-1:0]        half_x;
  logic [PW-1:0]        two_half;
  logic [PW-1:0]        span;
  logic                 active;
  logic                 is_tail;
  logic signed [AW-1:0] rad_ext;
  logic signed [AW-1:0] cand_up;
  logic signed [AW-1:0] cand_lo;

  assign half_x   = {1'b0, half};
  assign two_half = {half, 1'b0};
  assign active   = POS_V < two_half;
  assign is_tail  = POS_V == (two_half - PW'(1));
  assign span     = (POS_V >= half_x) ? (POS_V - half_x) : (half_x - POS_V);
  assign rad_ext  = $signed({{(AW-32){1'b0}}, radius});
  assign cand_up  = x + rad_ext;
  assign cand_lo  = x - rad_ext;

  always_comb begin
    out_valid = active;
    out_up    = cand_up;
    out_lo    = cand_lo;
    if (active && valid) begin
      out_up = (up > cand_up) ? up : cand_up;
      out_lo = (lo < cand_lo) ? lo : cand_lo;
    end
    out_center = (POS_V == half_x) ? x : center;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= is_tail ? 1'b0 : nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      up     <= nb_up;
      lo     <= nb_lo;
      center <= nb_center;
    end
    if (ctrl.load && (span == {1'b0, load_j})) begin
      radius <= load_radius;
    end
  end

endmodule

// File: design/elliptic_envelope_dilation.sv
// Elliptic tolerance envelope (grayscale dilation and erosion) of a sampled trace.
// Depends on eed_pkg, eed_root, eed_cell and elliptic_envelope_dilation_defines.svh.
//
// Use:
//   Samples enter on in_valid/in_stall with sample and last; envelope points leave
//   on out_valid/out_stall with upper, lower and final_res. A request moves on a
//   channel at a clock edge where valid is high and stall is low.
//   Registers half_window, margin and ratio_sq are written on cfg_valid/cfg_ready
//   (always ready) with cfg_index and cfg_data; a trace latches them at its first
//   sample, except the center term of each point, which uses the live margin.
//   The first sample of a trace is held while the radius table is built: after the
//   idle state, each of the (d+1) radii takes a start state and a pass through the
//   bit-serial square root unit.
//   After that one sample is taken per cycle, unless the output stalls, through a row of
//   2*MAX_HALF_WINDOW cells; each cell keeps one radius and passes a partial max/min
//   slot to its left neighbor. A point leaves in the cycle after the sample d later than it.
//   The last d points of a trace are dropped; last clears the row and the count.
//   A stalled output holds, and the input stalls until the held point is taken.
//   Synchronous reset clears the control state and returns the registers to their
//   reset values.
`include "elliptic_envelope_dilation_defines.svh"

module elliptic_envelope_dilation #(
  parameter int MAX_HALF_WINDOW = 64,
  parameter int SAMPLE_BITS     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS+1:0] upper,
  output logic signed [SAMPLE_BITS+1:0] lower,
  output logic                          final_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  localparam int DW = $clog2(MAX_HALF_WINDOW + 1);
  localparam int CW = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int NC = 2 * MAX_HALF_WINDOW;
  localparam int OW = SAMPLE_BITS + 2;
  localparam int AW = ((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32) + 2;
  localparam logic [CW-1:0] COUNT_MAX = CW'(NC);

  // configuration registers
  logic [6:0]  half_window;
  logic [30:0] margin;
  logic [31:0] ratio_sq;

  // per-trace latched values
  logic [DW-1:0] half;
  logic [31:0]   ratio_lat;
  logic [30:0]   margin_lat;
  logic [DW-1:0] j;
  logic [CW-1:0] count;

  eed_pkg::ctrl_state_t state, state_next;
  eed_pkg::cell_ctrl_t  cell_ctrl;

  logic        root_start;
  logic        root_done;
  logic [31:0] root_radius;
  logic        load;
  logic        accept;
  logic        emit;
  logic [DW-1:0] half_clamped;

  logic signed [AW-1:0] xs;
  logic signed [AW-1:0] marg_ext;
  logic signed [AW-1:0] cen;
  logic signed [AW-1:0] up_v;
  logic signed [AW-1:0] lo_v;

  logic                 ch_valid  [0:NC];
  logic signed [AW-1:0] ch_up     [0:NC];
  logic signed [AW-1:0] ch_lo     [0:NC];
  logic signed [AW-1:0] ch_center [0:NC];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= eed_pkg::HALF_WINDOW_RST;
      margin      <= eed_pkg::MARGIN_RST;
      ratio_sq    <= eed_pkg::RATIO_SQ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eed_pkg::CFG_HALF_WINDOW: half_window <= cfg_data[6:0];
        eed_pkg::CFG_MARGIN:      margin      <= cfg_data[30:0];
        eed_pkg::CFG_RATIO_SQ:    ratio_sq    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp the half window to what the row can hold
  assign half_clamped = (32'(half_window) > 32'(MAX_HALF_WINDOW)) ?
                        DW'(MAX_HALF_WINDOW) : DW'(half_window);

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      eed_pkg::T_IDLE:  if (in_valid) state_next = eed_pkg::T_BUILD;
      eed_pkg::T_BUILD: state_next = eed_pkg::T_WAIT;
      eed_pkg::T_WAIT: begin
        if (root_done) begin
          state_next = (j == half) ? eed_pkg::T_RUN : eed_pkg::T_BUILD;
        end
      end
      eed_pkg::T_RUN:   if (accept && last) state_next = eed_pkg::T_IDLE;
      default:          state_next = eed_pkg::T_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    root_start = 1'b0;
    load       = 1'b0;
    case (state)
      eed_pkg::T_BUILD: root_start = 1'b1;
      eed_pkg::T_WAIT:  load = root_done;
      eed_pkg::T_RUN:   in_stall = out_valid && out_stall;
      default: begin
      end
    endcase
  end

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && last;
  assign cell_ctrl.load  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eed_pkg::T_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (last) begin
          count <= '0;
        end else if (count < COUNT_MAX) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  // latch the trace setup at its first sample, advance the radius index
  always_ff @(posedge clk) begin
    if (state == eed_pkg::T_IDLE) begin
      half       <= half_clamped;
      ratio_lat  <= ratio_sq;
      margin_lat <= margin;
      j          <= '0;
    end else if (load) begin
      j <= j + DW'(1);
    end
  end

  eed_root #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .j     (j),
    .ratio (ratio_lat),
    .margin(margin_lat),
    .done  (root_done),
    .radius(root_radius)
  );

  assign xs = AW'(sample);

  // the far end of the row feeds empty slots
  assign ch_valid[NC]  = 1'b0;
  assign ch_up[NC]     = '0;
  assign ch_lo[NC]     = '0;
  assign ch_center[NC] = '0;

  for (genvar p = 0; p < NC; p++) begin : g_cell
    eed_cell #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
      .POS            (p)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .half       (half),
      .load_j     (j),
      .load_radius(root_radius),
      .x          (xs),
      .nb_valid   (ch_valid[p+1]),
      .nb_up      (ch_up[p+1]),
      .nb_lo      (ch_lo[p+1]),
      .nb_center  (ch_center[p+1]),
      .out_valid  (ch_valid[p]),
      .out_up     (ch_up[p]),
      .out_lo     (ch_lo[p]),
      .out_center (ch_center[p])
    );
  end

  // finish the point leaving cell zero: center term with live margin, zero baseline while count is below twice half
  assign marg_ext = $signed({{(AW-31){1'b0}}, margin});
  assign cen      = (half == '0) ? xs : ch_center[0];

  always_comb begin
    up_v = cen + marg_ext;
    lo_v = cen - marg_ext;
    if (ch_valid[0]) begin
      if (ch_up[0] > up_v) up_v = ch_up[0];
      if (ch_lo[0] < lo_v) lo_v = ch_lo[0];
    end
    if (count < CW'({half, 1'b0})) begin
      if (up_v < 0) up_v = '0;
      if (lo_v > 0) lo_v = '0;
    end
  end

  assign emit = accept && (count >= CW'(half));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      upper     <= up_v[OW-1:0];
      lower     <= lo_v[OW-1:0];
      final_res <= last;
    end
  end

  `EED_ASSERT_IMP(a_accept_in_run, accept, state == eed_pkg::T_RUN, "sample taken outside run")
  `EED_ASSERT_IMP(a_done_in_wait, root_done, state == eed_pkg::T_WAIT, "radius done while not waiting")
  `EED_ASSERT_NXT(a_emit_valid, emit, out_valid, "emitted point not presented")
  `EED_ASSERT_IMP(a_build_from_idle, root_start, half == j || j < half, "radius index past half window")

endmodule
